// File: rtl/jcp_pkg.sv
package jcp_pkg;

  // Default number of rotation cells and the size of the arctangent table
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TABLE_SIZE   = 24;

  // One result bit per cell for the magnitude square root
  localparam int SQRT_STEPS = 15;

  // Output constants, Q3.13 radians and Q7.8 distance
  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic [14:0]        MAG_LIMIT   = 15'd25600;
  localparam logic [16:0]        SUMSQ_LIMIT = 17'd10000;
  localparam logic [7:0]         AXIS_EDGE   = 8'd100;

  // Q3.13 radians per binary angle unit, scaled by 2^48
  localparam logic [31:0] RAD_SCALE = 32'd3373259426;

  typedef struct packed {
    logic signed [7:0] x_pos;
    logic signed [7:0] y_pos;
  } pos_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic [14:0]        magnitude;
  } polar_t;

  // Data handed from cell to cell
  typedef struct packed {
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [33:0] z;
    logic [29:0]        n;
    logic [17:0]        rem;
    logic [14:0]        root;
    logic               sat;
    logic               spec;
    logic signed [15:0] spec_val;
  } work_t;

  // Corrected axis for an edge position: floor(sqrt((20000 - k*k) * 2^32))
  typedef logic [23:0] fix_tab_t [0:128];

  function automatic fix_tab_t build_fix_tab();
    fix_tab_t          tab;
    longint unsigned   n;
    longint unsigned   root;
    longint unsigned   bitv;
    for (int k = 0; k <= 128; k++) begin
      n    = (64'd20000 - 64'(k * k)) << 32;
      root = 64'd0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      tab[k] = root[23:0];
    end
    return tab;
  endfunction

  localparam fix_tab_t FIX_TAB = build_fix_tab();

  // atan(2^-i) in binary angle units, 2^32 = 2*pi
  function automatic logic [31:0] atan_unit(input int idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/joystick_cartesian_to_polar.sv
// Joystick position to heading and clamped distance. Takes one (x_pos, y_pos)
// beat per clock while pos_ready is high and returns one (heading, magnitude)
// beat per position, in order. It has one prepare stage, a row of cells that
// each do one CORDIC rotation, one bit of the magnitude square root or both,
// and two output stages (scale multiply, then round and clamp). Every stage has
// its own valid bit, so bubbles close up and a new position is taken while a
// finished result waits at the output.
// heading is signed Q3.13 radians in [-pi, pi]; magnitude is Q7.8, held at
// 100.0 once the position lies outside the unit circle of radius 100.
module joystick_cartesian_to_polar #(
  parameter int CORDIC_STAGES = jcp_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pos_valid,
  output logic            pos_ready,
  input  jcp_pkg::pos_t   pos,
  output logic            polar_valid,
  input  logic            polar_ready,
  output jcp_pkg::polar_t polar
);

  localparam int ROT_CELLS = (CORDIC_STAGES < jcp_pkg::ATAN_TABLE_SIZE) ?
                             CORDIC_STAGES : jcp_pkg::ATAN_TABLE_SIZE;
  localparam int NCELLS    = (ROT_CELLS > jcp_pkg::SQRT_STEPS) ?
                             ROT_CELLS : jcp_pkg::SQRT_STEPS;

  logic           c_valid [0:NCELLS];
  logic           c_ready [0:NCELLS];
  jcp_pkg::work_t c_data  [0:NCELLS];

  jcp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pos_valid),
    .in_ready  (pos_ready),
    .in_data   (pos),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_data  (c_data[0])
  );

  // Row of rotation and root cells
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    jcp_cell #(
      .STAGE   (i),
      .DO_ROT  (i < ROT_CELLS),
      .DO_SQRT (i < jcp_pkg::SQRT_STEPS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_data   (c_data[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_data  (c_data[i+1])
    );
  end

  jcp_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[NCELLS]),
    .in_ready  (c_ready[NCELLS]),
    .in_data   (c_data[NCELLS]),
    .out_valid (polar_valid),
    .out_ready (polar_ready),
    .out_data  (polar)
  );

  // Results stay within their ranges
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    polar_valid |-> polar.magnitude <= jcp_pkg::MAG_LIMIT)
    else $error("magnitude above limit");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    polar_valid |-> (polar.heading <= jcp_pkg::PI_Q13 &&
                     polar.heading >= -jcp_pkg::PI_Q13))
    else $error("heading out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !polar_valid)
    else $error("result valid after reset");

endmodule

// File: rtl/jcp_prep.sv
module jcp_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jcp_pkg::pos_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jcp_pkg::work_t out_data
);

  logic [7:0]         ax, ay;
  logic [23:0]        cx_mag, cy_mag;
  logic [16:0]        sumsq;
  logic signed [26:0] ym;
  jcp_pkg::work_t     work_next;

  // Correct edge axes, fold the left half plane, flag the axis cases, load the root input and saturation flag
  always_comb begin
    ax = in_data.x_pos[7] ? (~in_data.x_pos + 8'd1) : in_data.x_pos;
    ay = in_data.y_pos[7] ? (~in_data.y_pos + 8'd1) : in_data.y_pos;
    cx_mag = (ax == jcp_pkg::AXIS_EDGE) ? jcp_pkg::FIX_TAB[ay] : {ax, 16'b0};
    cy_mag = (ay == jcp_pkg::AXIS_EDGE) ? jcp_pkg::FIX_TAB[ax] : {ay, 16'b0};
    sumsq  = 17'(ax * ax) + 17'(ay * ay);
    ym     = {3'b0, cy_mag};

    work_next.x = {3'b0, cx_mag};
    work_next.y = (in_data.x_pos[7] ^ in_data.y_pos[7]) ? -ym : ym;
    if (!in_data.x_pos[7]) begin
      work_next.z = '0;
    end else if (in_data.y_pos[7]) begin
      work_next.z = -34'sh080000000;
    end else begin
      work_next.z = 34'sh080000000;
    end
    work_next.n    = {sumsq[13:0], 16'b0};
    work_next.rem  = '0;
    work_next.root = '0;
    work_next.sat  = sumsq > jcp_pkg::SUMSQ_LIMIT;
    work_next.spec = (in_data.x_pos == 8'sd0) || (in_data.y_pos == 8'sd0);
    if (in_data.y_pos == 8'sd0) begin
      work_next.spec_val = in_data.x_pos[7] ? -jcp_pkg::PI_Q13 : 16'sd0;
    end else begin
      work_next.spec_val = in_data.y_pos[7] ? -jcp_pkg::HALF_PI_Q13
                                            : jcp_pkg::HALF_PI_Q13;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Advance the beat when the stage is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= work_next;
    end
  end

endmodule

// File: rtl/jcp_cell.sv
module jcp_cell #(
  parameter int STAGE   = 0,
  parameter bit DO_ROT  = 1'b1,
  parameter bit DO_SQRT = 1'b1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jcp_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jcp_pkg::work_t out_data
);

  logic signed [26:0] dx, dy;
  logic signed [33:0] da;
  logic [17:0]        rem_sh, trial;
  jcp_pkg::work_t     work_next;

  // One rotation step toward the x axis and one square root bit, each only where DO_ROT or DO_SQRT is set
  always_comb begin
    work_next = in_data;
    dx = in_data.y >>> STAGE;
    dy = in_data.x >>> STAGE;
    da = {2'b0, jcp_pkg::atan_unit(STAGE)};
    if (DO_ROT) begin
      if (!in_data.y[26]) begin
        work_next.x = in_data.x + dx;
        work_next.y = in_data.y - dy;
        work_next.z = in_data.z + da;
      end else begin
        work_next.x = in_data.x - dx;
        work_next.y = in_data.y + dy;
        work_next.z = in_data.z - da;
      end
    end
    rem_sh = {in_data.rem[15:0], in_data.n[29:28]};
    trial  = {1'b0, in_data.root, 2'b01};
    if (DO_SQRT) begin
      work_next.n = {in_data.n[27:0], 2'b00};
      if (rem_sh >= trial) begin
        work_next.rem  = rem_sh - trial;
        work_next.root = {in_data.root[13:0], 1'b1};
      end else begin
        work_next.rem  = rem_sh;
        work_next.root = {in_data.root[13:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= work_next;
    end
  end

endmodule

// File: rtl/jcp_post.sv
module jcp_post (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  jcp_pkg::work_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output jcp_pkg::polar_t out_data
);

  // Scale stage registers
  logic               a_valid;
  logic               a_ready;
  logic [63:0]        a_prod;
  logic               a_neg;
  logic               a_spec;
  logic signed [15:0] a_spec_val;
  logic [14:0]        a_mag;

  logic [31:0]        absz;
  logic [14:0]        mag_next;
  logic [16:0]        h_round;
  logic [15:0]        h_clamp;
  jcp_pkg::polar_t    res_next;

  // Take |z| and round the square root to nearest, or saturate at MAG_LIMIT
  always_comb begin
    absz = in_data.z[33] ? 32'(-in_data.z) : in_data.z[31:0];
    if (in_data.sat) begin
      mag_next = jcp_pkg::MAG_LIMIT;
    end else if (in_data.rem > {3'b0, in_data.root}) begin
      mag_next = in_data.root + 15'd1;
    end else begin
      mag_next = in_data.root;
    end
  end

  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  // Convert binary angle units to radians
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_prod     <= 64'(absz) * 64'(jcp_pkg::RAD_SCALE);
      a_neg      <= in_data.z[33];
      a_spec     <= in_data.spec;
      a_spec_val <= in_data.spec_val;
      a_mag      <= mag_next;
    end
  end

  // Round half up, clamp at pi, restore the sign, or take the axis value
  always_comb begin
    h_round = {1'b0, a_prod[63:48]} + {16'b0, a_prod[47]};
    h_clamp = (h_round > {1'b0, jcp_pkg::PI_Q13}) ? jcp_pkg::PI_Q13 : h_round[15:0];
    if (a_spec) begin
      res_next.heading = a_spec_val;
    end else if (a_neg) begin
      res_next.heading = -$signed(h_clamp);
    end else begin
      res_next.heading = $signed(h_clamp);
    end
    res_next.magnitude = a_mag;
  end

  assign a_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      out_data <= res_next;
    end
  end

endmodule

// File: tb/tb_joystick_cartesian_to_polar.sv
module tb_joystick_cartesian_to_polar;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES   = 16;
  localparam int TAIL     = 60;
  localparam int WDOG_MAX = 5000;
  localparam int N_RAND   = 1750;

  logic            clk;
  logic            rst;
  logic            pos_valid;
  logic            pos_ready;
  jcp_pkg::pos_t   pos;
  logic            polar_valid;
  logic            polar_ready;
  jcp_pkg::polar_t polar;

  jcp_pkg::polar_t expected_polar[$];
  int     mismatches;
  int     idle_cycles;
  bit     feed_done;

  joystick_cartesian_to_polar #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst),
    .pos_valid(pos_valid), .pos_ready(pos_ready), .pos(pos),
    .polar_valid(polar_valid), .polar_ready(polar_ready), .polar(polar)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n    = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Replace an edge axis by the corrected length
  function automatic longint edge_axis(longint other_sq, bit neg);
    longint t;
    longint r;
    t = 64'sd20000 * (64'sd1 << 32) - other_sq;
    if (t < 0) t = 0;
    r = longint'(isqrt(unsigned'(t)));
    return neg ? -r : r;
  endfunction

  function automatic longint atan_bam(int i);
    longint a;
    case (i)
      0: a = 'h20000000;  1: a = 'h12E4051E;  2: a = 'h09FB385B;  3: a = 'h051111D4;
      4: a = 'h028B0D43;  5: a = 'h0145D7E1;  6: a = 'h00A2F61E;  7: a = 'h00517C55;
      8: a = 'h0028BE53;  9: a = 'h00145F2F; 10: a = 'h000A2F98; 11: a = 'h000517CC;
      12: a = 'h00028BE6; 13: a = 'h000145F3; 14: a = 'h0000A2FA; 15: a = 'h0000517D;
      16: a = 'h000028BE; 17: a = 'h0000145F; 18: a = 'h00000A30; 19: a = 'h00000518;
      20: a = 'h0000028C; 21: a = 'h00000146; 22: a = 'h000000A3; 23: a = 'h00000051;
      default: a = 0;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] heading_of(longint x, longint y);
    longint cx, cy, z, dx, dy, h;
    longint unsigned m;
    cx = x * 65536;
    cy = y * 65536;
    z  = 0;
    if (x == 100 || x == -100) cx = edge_axis(y * y * (64'sd1 << 32), x < 0);
    if (y == 100 || y == -100) cy = edge_axis(cx * cx, y < 0);
    if (cx == 0 && cy == 0) return 16'sd0;
    if (cx == 0) return (cy > 0) ? jcp_pkg::HALF_PI_Q13 : -jcp_pkg::HALF_PI_Q13;
    if (cy == 0) return (cx < 0) ? -jcp_pkg::PI_Q13 : 16'sd0;
    // Rotate left half-plane by pi
    if (cx < 0) begin
      z  = (cy > 0) ? (64'sd1 << 31) : -(64'sd1 << 31);
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < STAGES && i < jcp_pkg::ATAN_TABLE_SIZE; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += atan_bam(i);
      end else begin
        cx -= dx; cy += dy; z -= atan_bam(i);
      end
    end
    m = unsigned'(z < 0 ? -z : z);
    h = longint'((m * 64'd3373259426 + (64'd1 << 47)) >> 48);
    if (h > 25736) h = 25736;
    if (z < 0) h = -h;
    return h[15:0];
  endfunction

  function automatic logic [14:0] magnitude_of(longint x, longint y);
    longint unsigned s, n, r;
    s = unsigned'(x * x + y * y);
    if (s > 10000) return jcp_pkg::MAG_LIMIT;
    n = s << 16;
    r = isqrt(n);
    if (n - r * r > r) r++;
    return r[14:0];
  endfunction

  function automatic jcp_pkg::polar_t polar_of(jcp_pkg::pos_t p);
    jcp_pkg::polar_t o;
    o.heading   = heading_of(longint'(p.x_pos), longint'(p.y_pos));
    o.magnitude = magnitude_of(longint'(p.x_pos), longint'(p.y_pos));
    return o;
  endfunction

  // Directed stimulus; known results typed where obvious
  typedef struct {
    int x;
    int y;
    bit typed;
    int hd;
    int mg;
  } vec_t;

  vec_t dir_tab [25] = '{
    '{0, 0, 1, 0, 0},
    '{0, 50, 1, 12868, 12800},
    '{0, -50, 1, -12868, 12800},
    '{-50, 0, 1, -25736, 12800},
    '{50, 0, 1, 0, 12800},
    '{100, 0, 1, 0, 25600},
    '{-100, 0, 1, -25736, 25600},
    '{0, 100, 1, 12868, 25600},
    '{0, -100, 1, -12868, 25600},
    '{60, 80, 1, 0, 25600},
    '{127, 127, 1, 0, 25600},
    '{-127, -127, 1, 0, 25600},
    '{127, -127, 0, 0, 0},
    '{-127, 127, 0, 0, 0},
    '{100, 100, 0, 0, 0},
    '{-100, -100, 0, 0, 0},
    '{100, -100, 0, 0, 0},
    '{-100, 100, 0, 0, 0},
    '{-100, 37, 0, 0, 0},
    '{-3, 100, 0, 0, 0},
    '{-1, -1, 0, 0, 0},
    '{1, 1, 0, 0, 0},
    '{-60, -80, 0, 0, 0},
    '{61, 80, 0, 0, 0},
    '{-85, 1, 0, 0, 0}
  };

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 100 : -100;
    if (r == 1) return 0;
    if (r < 5) return $urandom_range(0, 20) - 10;
    return $urandom_range(0, 254) - 127;
  endfunction

  // Send one beat and queue its expectation on acceptance
  task automatic send_pos(jcp_pkg::pos_t p, jcp_pkg::polar_t e);
    int g;
    g = gap_len();
    if (g > 0) begin
      pos_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pos_valid <= 1'b1;
    pos       <= p;
    do @(posedge clk); while (!pos_ready);
    expected_polar.push_back(e);
  endtask

  // Stimulus
  initial begin
    jcp_pkg::pos_t   p;
    jcp_pkg::polar_t e;
    rst       = 1'b1;
    pos_valid = 1'b0;
    pos       = '0;
    feed_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      p.x_pos = dir_tab[i].x[7:0];
      p.y_pos = dir_tab[i].y[7:0];
      if (dir_tab[i].typed) begin
        e.heading   = dir_tab[i].hd[15:0];
        e.magnitude = dir_tab[i].mg[14:0];
        // corners and far points: heading left to the predictor
        if (dir_tab[i].x == 60 || dir_tab[i].x == 127 || dir_tab[i].x == -127)
          e.heading = polar_of(p).heading;
      end else begin
        e = polar_of(p);
      end
      send_pos(p, e);
    end
    for (int i = 0; i < N_RAND; i++) begin
      p.x_pos = 8'(rand_axis());
      p.y_pos = 8'(rand_axis());
      send_pos(p, polar_of(p));
    end
    pos_valid <= 1'b0;
    feed_done = 1'b1;
  end

  // Drain side: compare against oldest expectation, drive ready
  initial begin
    int              stall;
    jcp_pkg::polar_t e;
    mismatches  = 0;
    polar_ready = 1'b0;
    stall       = 0;
    forever begin
      @(posedge clk);
      if (!rst && polar_valid && polar_ready) begin
        if (expected_polar.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: heading %0d magnitude %0d",
                     polar.heading, polar.magnitude);
        end else begin
          e = expected_polar.pop_front();
          if (polar.heading !== e.heading || polar.magnitude !== e.magnitude) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected heading %0d magnitude %0d, got %0d %0d",
                       e.heading, e.magnitude, polar.heading, polar.magnitude);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        polar_ready <= 1'b0;
      end else begin
        stall = gap_len();
        polar_ready <= (stall == 0);
      end
    end
  end

  // Watchdog on cycles with no accepted beat
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((pos_valid && pos_ready) || (polar_valid && polar_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("joystick_cartesian_to_polar regression: fail");
        $finish;
      end
    end
  end

  // Finish once drained
  initial begin
    wait (feed_done);
    while (expected_polar.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && expected_polar.size() == 0) begin
      $display("joystick_cartesian_to_polar regression: pass");
    end else begin
      $display("joystick_cartesian_to_polar regression: fail");
    end
    $finish;
  end
endmodule
